// ----- rtl/core/ptt_pkg.sv -----
// Shared constants, function codes and control structs for the periodic task timer table.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

   // table geometry and field widths
   localparam int MAX_CHANNELS = 16;
   localparam int CH_W         = $clog2(MAX_CHANNELS);
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
   localparam int TICK_W       = 32;
   localparam int FUNC_W       = 3;
   localparam int LIMIT_W      = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_CHANNELS);

   // operation codes carried in func
   localparam logic [FUNC_W-1:0] FUNC_BIND     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REBIND   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MODE     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_INTERVAL = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESUME   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STOP     = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_POLL     = 3'd6;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic scan_commit;
      logic scan_advance;
      logic finish;
   } ptt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_poll;
      logic is_bind;
      logic out_free;
      logic fire;
      logic pend_valid;
      logic scan_last;
      logic none_bound;
   } ptt_status_type;

endpackage
`default_nettype wire

// ----- rtl/core/ptt_req_if.sv -----
// Request channel interface: valid/ready plus one operation word.
// Depends on ptt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ptt_req_if;
   import ptt_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CH_W-1:0]   task_index;
   logic [TICK_W-1:0] interval;
   logic              oneshot;
   logic [TICK_W-1:0] now;

   modport source (output valid, func, task_index, interval, oneshot, now, input ready);
   modport sink   (input valid, func, task_index, interval, oneshot, now, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/ptt_rsp_if.sv -----
// Response channel interface: valid/ready plus one result word.
// Depends on ptt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ptt_rsp_if;
   import ptt_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] channel;
   logic            fired;
   logic            bind_ok;
   logic            last;

   modport source (output valid, channel, fired, bind_ok, last, input ready);
   modport sink   (input valid, channel, fired, bind_ok, last, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/ptt_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ptt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/core/ptt_ctrl.sv -----
// Sequencer for the timer table: accepts a word, executes it or walks the channel scan.
// Depends on ptt_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module ptt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ptt_pkg::ptt_status_type status,
   output ptt_pkg::ptt_cmd_type         cmd
);
   import ptt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_poll) begin
               state_in = status.none_bound ? ST_FINISH : ST_SCAN;
            end else if (!status.is_bind || status.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // hold while an earlier firing word cannot leave
            if (!(status.fire && status.pend_valid && !status.out_free)) begin
               cmd.scan_commit = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.scan_advance = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a poll always closes with the finish step before new work
   a_poll_finishes: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_commit && status.scan_last) |=> (state_ff == ST_FINISH))
      else $error("scan of last channel did not lead to finish");

   // scan never advances past a stalled firing
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.fire && status.pend_valid && !status.out_free)
      |-> (!cmd.scan_commit && !cmd.scan_advance))
      else $error("scan moved while a firing word was blocked");

   // words are only taken while nothing is in progress
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_EXEC && !req_ready))
      else $error("accepted word did not start execution");

endmodule
`default_nettype wire

// ----- rtl/core/ptt_datapath.sv -----
// Timer table datapath: item registers, channel tables, flags, scan compare and result register.
// Depends on ptt_pkg and ptt_ram.
`timescale 1ns / 1ps
`default_nettype none
module ptt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [ptt_pkg::FUNC_W-1:0]          req_func,
   input  wire logic [ptt_pkg::CH_W-1:0]            req_task_index,
   input  wire logic [ptt_pkg::TICK_W-1:0]          req_interval,
   input  wire logic                                req_oneshot,
   input  wire logic [ptt_pkg::TICK_W-1:0]          req_now,
   input  wire logic [ptt_pkg::LIMIT_W-1:0]         task_limit,
   input  wire ptt_pkg::ptt_cmd_type                cmd,
   output ptt_pkg::ptt_status_type                  status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [ptt_pkg::CH_W-1:0]            rsp_channel,
   output logic                                     rsp_fired,
   output logic                                     rsp_bind_ok,
   output logic                                     rsp_last
);
   import ptt_pkg::*;

   // latched request word
   logic [FUNC_W-1:0] func_ff;
   logic [CH_W-1:0]   idx_ff;
   logic [TICK_W-1:0] ival_ff;
   logic              item_oneshot_ff;
   logic [TICK_W-1:0] now_ff;

   // channel state
   logic [CNT_W-1:0]        bound_count_ff;
   logic [MAX_CHANNELS-1:0] running_ff;
   logic [MAX_CHANNELS-1:0] oneshot_ff;

   // scan state
   logic [CH_W-1:0] scan_idx_ff;
   logic            pend_valid_ff;
   logic [CH_W-1:0] pend_ch_ff;

   // result register
   logic            out_valid_ff;
   logic [CH_W-1:0] out_ch_ff;
   logic            out_fired_ff;
   logic            out_ok_ff;
   logic            out_last_ff;

   // ram ports
   logic              period_we;
   logic [CH_W-1:0]   period_waddr;
   logic              base_we;
   logic [CH_W-1:0]   base_waddr;
   logic [TICK_W-1:0] base_wdata;
   logic [CH_W-1:0]   rd_addr;
   logic [TICK_W-1:0] period_rd;
   logic [TICK_W-1:0] base_rd;

   // decode and compare
   logic [CNT_W-1:0]  limit_eff;
   logic              bind_ok;
   logic              idx_valid;
   logic [CH_W-1:0]   bind_ch;
   logic              is_bind;
   logic [TICK_W-1:0] elapsed;
   logic              fire;
   logic [TICK_W-1:0] next_base;
   logic              scan_last;
   logic              out_free;

   // result load
   logic            out_load;
   logic [CH_W-1:0] out_ch_in;
   logic            out_fired_in;
   logic            out_ok_in;
   logic            out_last_in;

   // capture the request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff         <= req_func;
         idx_ff          <= req_task_index;
         ival_ff         <= req_interval;
         item_oneshot_ff <= req_oneshot;
         now_ff          <= req_now;
      end
   end

   // limit clamp and index checks
   assign limit_eff = (CNT_W'(task_limit) > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                                  : CNT_W'(task_limit);
   assign bind_ok   = bound_count_ff < limit_eff;
   assign idx_valid = CNT_W'(idx_ff) < bound_count_ff;
   assign bind_ch   = bound_count_ff[CH_W-1:0];
   assign is_bind   = func_ff == FUNC_BIND;

   // elapsed time against period for the scanned channel
   assign elapsed   = now_ff - base_rd;
   assign fire      = running_ff[scan_idx_ff] && (elapsed >= period_rd);
   assign next_base = (period_rd != '0) ? (base_rd + period_rd) : now_ff;
   assign scan_last = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == bound_count_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   // read the next channel ahead when the scan moves on
   assign rd_addr = cmd.scan_advance ? (scan_idx_ff + CH_W'(1)) : scan_idx_ff;

   // period table writes
   assign period_we    = cmd.exec && ((is_bind && bind_ok) ||
                         ((func_ff == FUNC_REBIND || func_ff == FUNC_INTERVAL) && idx_valid));
   assign period_waddr = is_bind ? bind_ch : idx_ff;

   // base table writes
   always_comb begin
      base_we    = 1'b0;
      base_waddr = idx_ff;
      base_wdata = now_ff;
      if (cmd.exec && is_bind && bind_ok) begin
         base_we    = 1'b1;
         base_waddr = bind_ch;
      end else if (cmd.exec && func_ff == FUNC_RESUME && idx_valid && !running_ff[idx_ff]) begin
         base_we    = 1'b1;
      end else if (cmd.scan_commit && fire) begin
         base_we    = 1'b1;
         base_waddr = scan_idx_ff;
         base_wdata = next_base;
      end
   end

   ptt_ram #(.WIDTH(TICK_W), .DEPTH(MAX_CHANNELS)) u_period_ram (
      .clock   (clock),
      .wr_en   (period_we),
      .wr_addr (period_waddr),
      .wr_data (ival_ff),
      .rd_addr (rd_addr),
      .rd_data (period_rd)
   );

   ptt_ram #(.WIDTH(TICK_W), .DEPTH(MAX_CHANNELS)) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (base_waddr),
      .wr_data (base_wdata),
      .rd_addr (rd_addr),
      .rd_data (base_rd)
   );

   // bound count and running flags
   always_ff @(posedge clock) begin
      if (reset) begin
         bound_count_ff <= '0;
         running_ff     <= '0;
      end else begin
         if (cmd.exec && is_bind && bind_ok) begin
            bound_count_ff      <= bound_count_ff + CNT_W'(1);
            running_ff[bind_ch] <= 1'b1;
         end else if (cmd.exec && func_ff == FUNC_RESUME && idx_valid) begin
            running_ff[idx_ff]  <= 1'b1;
         end else if (cmd.exec && func_ff == FUNC_STOP && idx_valid) begin
            running_ff[idx_ff]  <= 1'b0;
         end else if (cmd.scan_commit && fire && oneshot_ff[scan_idx_ff]) begin
            running_ff[scan_idx_ff] <= 1'b0;
         end
      end
   end

   // mode flags
   always_ff @(posedge clock) begin
      if (cmd.exec && is_bind && bind_ok) begin
         oneshot_ff[bind_ch] <= item_oneshot_ff;
      end else if (cmd.exec && (func_ff == FUNC_REBIND || func_ff == FUNC_MODE) && idx_valid) begin
         oneshot_ff[idx_ff]  <= item_oneshot_ff;
      end
   end

   // scan index and the held firing channel
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         scan_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.scan_advance) begin
            scan_idx_ff <= scan_idx_ff + CH_W'(1);
         end
         if (cmd.scan_commit && fire) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_commit && fire) begin
         pend_ch_ff <= scan_idx_ff;
      end
   end

   // result word selection
   always_comb begin
      out_load     = 1'b0;
      out_ch_in    = '0;
      out_fired_in = 1'b0;
      out_ok_in    = 1'b0;
      out_last_in  = 1'b0;
      if (cmd.exec && is_bind) begin
         out_load    = 1'b1;
         out_last_in = 1'b1;
         if (bind_ok) begin
            out_ch_in = bind_ch;
            out_ok_in = 1'b1;
         end
      end else if (cmd.scan_commit && fire && pend_valid_ff) begin
         out_load     = 1'b1;
         out_ch_in    = pend_ch_ff;
         out_fired_in = 1'b1;
      end else if (cmd.finish) begin
         out_load    = 1'b1;
         out_last_in = 1'b1;
         if (pend_valid_ff) begin
            out_ch_in    = pend_ch_ff;
            out_fired_in = 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ch_ff    <= out_ch_in;
         out_fired_ff <= out_fired_in;
         out_ok_ff    <= out_ok_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_channel = out_ch_ff;
   assign rsp_fired   = out_fired_ff;
   assign rsp_bind_ok = out_ok_ff;
   assign rsp_last    = out_last_ff;

   // status back to the sequencer
   assign status.is_poll    = func_ff == FUNC_POLL;
   assign status.is_bind    = is_bind;
   assign status.out_free   = out_free;
   assign status.fire       = fire;
   assign status.pend_valid = pend_valid_ff;
   assign status.scan_last  = scan_last;
   assign status.none_bound = bound_count_ff == '0;

   // a result word never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten");

   // bound count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bound_count_ff <= CNT_W'(MAX_CHANNELS))
      else $error("bound count beyond table size");

   // only a successful bind changes the bound count
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && is_bind && bind_ok) |=> $stable(bound_count_ff))
      else $error("bound count changed without bind");

   // a one-shot channel stops once it fires
   a_oneshot_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_commit && fire && oneshot_ff[scan_idx_ff])
      |=> !running_ff[$past(scan_idx_ff)])
      else $error("one-shot channel still running after firing");

endmodule
`default_nettype wire

// ----- rtl/core/periodic_task_timer_table_top.sv -----
// Top level of the periodic task timer table: channel interfaces, limit register,
// sequencer and datapath. Depends on ptt_pkg, ptt_req_if, ptt_rsp_if, ptt_ctrl, ptt_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Timing: a word is taken only while idle and is executed before the next one is taken; a bind
//   waits in execute while the result register is full, and its result is shown the cycle after
//   execute. A poll scans the N bound channels, one channel per cycle through the single compare
//   unit and the registered table reads while no firing result is blocked, then finishes.
// Reset: clears the bound count, running flags, scan state and result register, and sets
//   task_limit to 16; period, base and mode entries are written before any read and need no pass.
module periodic_task_timer_table_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ptt_req_if.sink                            req_chan,
   ptt_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ptt_pkg::LIMIT_W-1:0]   csr_data
);
   import ptt_pkg::*;

   logic [LIMIT_W-1:0] task_limit_ff;
   ptt_cmd_type        cmd;
   ptt_status_type     status;

   // limit register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         task_limit_ff <= csr_data;
      end
   end

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ptt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_chan.func),
      .req_task_index (req_chan.task_index),
      .req_interval   (req_chan.interval),
      .req_oneshot    (req_chan.oneshot),
      .req_now        (req_chan.now),
      .task_limit     (task_limit_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_channel    (rsp_chan.channel),
      .rsp_fired      (rsp_chan.fired),
      .rsp_bind_ok    (rsp_chan.bind_ok),
      .rsp_last       (rsp_chan.last)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the periodic task timer table: directed table, then random words.
// Depends on ptt_pkg, ptt_req_if, ptt_rsp_if and periodic_task_timer_table_top.
`timescale 1ns / 1ps
module tb;
   import ptt_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int MAX_SHOWN        = 10;
   localparam int RANDOM_PER_PHASE = 102;
   localparam int DRAIN_EVERY      = 40;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CH_W-1:0]   task_index;
      logic [TICK_W-1:0] interval;
      logic              oneshot;
      logic [TICK_W-1:0] now;
   } timer_word_type;

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic            fired;
      logic            bind_ok;
      logic            last;
   } timer_report_type;

   typedef enum bit {ROW_WORD, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      timer_word_type     word;
      logic [LIMIT_W-1:0] limit;
      bit                 typed;
      timer_report_type   report;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_data;

   ptt_req_if req_bus ();
   ptt_rsp_if rsp_bus ();

   periodic_task_timer_table_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // shadow copy of the timer table
   logic [LIMIT_W-1:0] limit_r;
   logic [CNT_W-1:0]   bound_n;
   logic [TICK_W-1:0]  period_q  [MAX_CHANNELS];
   logic [TICK_W-1:0]  base_q    [MAX_CHANNELS];
   logic               running_q [MAX_CHANNELS];
   logic               oneshot_q [MAX_CHANNELS];

   timer_report_type pending_reports[$];
   directed_row_type directed_rows[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;
   int words_sent;
   int polls_sent;
   int binds_granted;
   int reports_checked;
   int fires_seen;
   logic [TICK_W-1:0] tick_now;

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicts the reports one word causes and updates the shadow table
   function automatic void timer_table_apply(input timer_word_type w);
      logic [CNT_W-1:0]  cap;
      logic              in_table;
      logic [TICK_W-1:0] elapsed;
      timer_report_type  r;
      timer_report_type  batch[$];
      cap = (limit_r > LIMIT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : CNT_W'(limit_r);
      in_table = CNT_W'(w.task_index) < bound_n;
      r = '0;
      r.last = 1'b1;
      case (w.func)
         FUNC_BIND: begin
            if (bound_n < cap) begin
               period_q[bound_n]  = w.interval;
               oneshot_q[bound_n] = w.oneshot;
               if (!running_q[bound_n]) begin
                  base_q[bound_n]    = w.now;
                  running_q[bound_n] = 1'b1;
               end
               r.channel = CH_W'(bound_n);
               r.bind_ok = 1'b1;
               bound_n++;
               binds_granted++;
            end
            pending_reports.push_back(r);
         end
         FUNC_REBIND: begin
            if (in_table) begin
               period_q[w.task_index]  = w.interval;
               oneshot_q[w.task_index] = w.oneshot;
            end
         end
         FUNC_MODE: begin
            if (in_table) oneshot_q[w.task_index] = w.oneshot;
         end
         FUNC_INTERVAL: begin
            if (in_table) period_q[w.task_index] = w.interval;
         end
         FUNC_RESUME: begin
            if (in_table && !running_q[w.task_index]) begin
               base_q[w.task_index]    = w.now;
               running_q[w.task_index] = 1'b1;
            end
         end
         FUNC_STOP: begin
            if (in_table) running_q[w.task_index] = 1'b0;
         end
         FUNC_POLL: begin
            polls_sent++;
            // scan bound channels in index order against one timestamp
            for (int i = 0; i < MAX_CHANNELS; i++) begin
               if (CNT_W'(i) < bound_n && running_q[i]) begin
                  elapsed = w.now - base_q[i];
                  if (elapsed >= period_q[i]) begin
                     base_q[i] = (period_q[i] != '0) ? base_q[i] + period_q[i] : w.now;
                     if (oneshot_q[i]) running_q[i] = 1'b0;
                     r = '0;
                     r.channel = CH_W'(i);
                     r.fired = 1'b1;
                     batch.push_back(r);
                  end
               end
            end
            if (batch.size() == 0) begin
               r = '0;
               r.last = 1'b1;
               pending_reports.push_back(r);
            end else begin
               batch[batch.size()-1].last = 1'b1;
               foreach (batch[k]) pending_reports.push_back(batch[k]);
            end
         end
         default: ;
      endcase
   endfunction

   // random word: mostly a slowly advancing clock, small periods, bound indices
   function automatic timer_word_type make_timer_word();
      timer_word_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 34)      w.func = FUNC_POLL;
      else if (pick < 50) w.func = FUNC_BIND;
      else if (pick < 60) w.func = FUNC_REBIND;
      else if (pick < 68) w.func = FUNC_MODE;
      else if (pick < 78) w.func = FUNC_INTERVAL;
      else if (pick < 88) w.func = FUNC_RESUME;
      else if (pick < 97) w.func = FUNC_STOP;
      else                w.func = FUNC_UNUSED;
      if ($urandom_range(99) < 4) tick_now = $urandom;
      else tick_now = tick_now + TICK_W'($urandom_range(0, 12));
      w.now = ($urandom_range(99) < 5) ? TICK_W'($urandom) : tick_now;
      pick = $urandom_range(99);
      if (pick < 10)      w.interval = '0;
      else if (pick < 65) w.interval = TICK_W'($urandom_range(1, 40));
      else if (pick < 80) w.interval = TICK_W'($urandom_range(41, 1000));
      else                w.interval = TICK_W'($urandom);
      w.oneshot = ($urandom_range(0, 3) == 0);
      if (bound_n != 0 && $urandom_range(99) < 80)
         w.task_index = CH_W'($urandom_range(0, int'(bound_n) - 1));
      else
         w.task_index = CH_W'($urandom_range(0, MAX_CHANNELS - 1));
      return w;
   endfunction

   // directed table builders
   task automatic add_word(input logic [FUNC_W-1:0] func, input int idx,
                           input logic [TICK_W-1:0] ival, input logic shot,
                           input logic [TICK_W-1:0] stamp);
      directed_row_type row;
      row.kind = ROW_WORD;
      row.word.func = func;
      row.word.task_index = CH_W'(idx);
      row.word.interval = ival;
      row.word.oneshot = shot;
      row.word.now = stamp;
      row.limit = '0;
      row.typed = 1'b0;
      row.report = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [FUNC_W-1:0] func, input logic [TICK_W-1:0] ival,
                            input logic shot, input logic [TICK_W-1:0] stamp,
                            input int ch, input logic ok);
      add_word(func, 0, ival, shot, stamp);
      directed_rows[directed_rows.size()-1].typed = 1'b1;
      directed_rows[directed_rows.size()-1].report.channel = CH_W'(ch);
      directed_rows[directed_rows.size()-1].report.bind_ok = ok;
      directed_rows[directed_rows.size()-1].report.last = 1'b1;
   endtask

   task automatic add_limit(input logic [LIMIT_W-1:0] value);
      directed_row_type row;
      row.kind = ROW_LIMIT;
      row.word = '0;
      row.limit = value;
      row.typed = 1'b0;
      row.report = '0;
      directed_rows.push_back(row);
   endtask

   // drive one word from a falling edge, hold until accepted
   task automatic send_word(input timer_word_type w, input bit typed,
                            input timer_report_type report);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.func       = w.func;
      req_bus.task_index = w.task_index;
      req_bus.interval   = w.interval;
      req_bus.oneshot    = w.oneshot;
      req_bus.now        = w.now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      timer_table_apply(w);
      if (typed) begin
         pending_reports.delete(pending_reports.size() - 1);
         pending_reports.push_back(report);
      end
      words_sent++;
      @(negedge clock);
   endtask

   // hold off until every expected report is in, then let a trailing update finish
   task automatic drain_reports();
      req_bus.valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_r = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // receiver back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker
   timer_report_type got_report;
   timer_report_type want_report;
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_report.channel = rsp_bus.channel;
         got_report.fired   = rsp_bus.fired;
         got_report.bind_ok = rsp_bus.bind_ok;
         got_report.last    = rsp_bus.last;
         reports_checked++;
         if (got_report.fired === 1'b1) fires_seen++;
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("%0t: unexpected report ch=%0d fired=%b ok=%b last=%b", $realtime,
                        got_report.channel, got_report.fired, got_report.bind_ok,
                        got_report.last);
         end else begin
            want_report = pending_reports.pop_front();
            if (got_report.channel !== want_report.channel ||
                got_report.fired   !== want_report.fired ||
                got_report.bind_ok !== want_report.bind_ok ||
                got_report.last    !== want_report.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("%0t: exp ch=%0d f=%b ok=%b l=%b, got ch=%0d f=%b ok=%b l=%b",
                           $realtime, want_report.channel, want_report.fired,
                           want_report.bind_ok, want_report.last, got_report.channel,
                           got_report.fired, got_report.bind_ok, got_report.last);
            end
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   int quiet_cycles;
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb NOT OK");
      $finish;
   end

   // main sequence
   logic [LIMIT_W-1:0] phase_limit [3];
   int                 phase_send  [3];
   int                 phase_recv  [3];
   timer_word_type     rand_word;
   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_POLL;
      req_bus.task_index = '0;
      req_bus.interval = '0;
      req_bus.oneshot = 1'b0;
      req_bus.now = '0;
      send_idle_pct = 35;
      recv_idle_pct = 79;
      mismatch_count = 0;
      words_sent = 0;
      polls_sent = 0;
      binds_granted = 0;
      reports_checked = 0;
      fires_seen = 0;
      tick_now = '0;
      limit_r = LIMIT_RESET;
      bound_n = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         period_q[i] = '0;
         base_q[i] = '0;
         running_q[i] = 1'b0;
         oneshot_q[i] = 1'b0;
      end
      phase_limit[0] = 5'd9;  phase_send[0] = 35; phase_recv[0] = 79;
      phase_limit[1] = 5'd31; phase_send[1] = 79; phase_recv[1] = 35;
      phase_limit[2] = 5'd4;  phase_send[2] = 0;  phase_recv[2] = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table, unbound indices, unused selector
      add_typed(FUNC_POLL, '0, 1'b0, 32'd0, 0, 1'b0);
      add_word(FUNC_STOP, 15, 32'd0, 1'b0, 32'd0);
      add_word(FUNC_RESUME, 0, 32'd0, 1'b0, 32'd7);
      add_word(FUNC_UNUSED, 5, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      // zero limit blocks binding
      add_limit(5'd0);
      add_typed(FUNC_BIND, 32'd5, 1'b0, 32'd0, 0, 1'b0);
      // fill a table of three, fourth bind refused
      add_limit(5'd3);
      add_typed(FUNC_BIND, 32'd10, 1'b0, 32'd100, 0, 1'b1);
      add_typed(FUNC_BIND, 32'd0, 1'b0, 32'd100, 1, 1'b1);
      add_typed(FUNC_BIND, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFF0, 2, 1'b1);
      add_typed(FUNC_BIND, 32'd1, 1'b0, 32'd100, 0, 1'b0);
      // zero period fires every poll, wrapped elapsed time on channel 2
      add_word(FUNC_POLL, 0, 32'd0, 1'b0, 32'd105);
      add_word(FUNC_POLL, 0, 32'd0, 1'b0, 32'd110);
      // resume while running is a no-op, stop then resume restamps
      add_word(FUNC_RESUME, 0, 32'd0, 1'b0, 32'd500);
      add_word(FUNC_STOP, 0, 32'd0, 1'b0, 32'd0);
      add_word(FUNC_RESUME, 0, 32'd0, 1'b0, 32'd1000);
      add_word(FUNC_MODE, 0, 32'd0, 1'b1, 32'd0);
      add_word(FUNC_INTERVAL, 1, 32'd3, 1'b0, 32'd0);
      add_word(FUNC_REBIND, 2, 32'd1, 1'b0, 32'd0);
      add_word(FUNC_POLL, 0, 32'd0, 1'b0, 32'hFFFF_FFFF);
      add_word(FUNC_POLL, 0, 32'd0, 1'b0, 32'd0);
      add_word(FUNC_REBIND, 3, 32'hFFFF_FFFF, 1'b1, 32'd0);
      add_word(FUNC_POLL, 0, 32'd0, 1'b0, 32'd2000);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_LIMIT) begin
            drain_reports();
            write_limit(directed_rows[r].limit);
         end else begin
            send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].report);
         end
      end

      // random phases, each with its own limit and pacing
      for (int p = 0; p < 3; p++) begin
         drain_reports();
         write_limit(phase_limit[p]);
         send_idle_pct = phase_send[p];
         recv_idle_pct = phase_recv[p];
         if (p == 1) tick_now = 32'hFFFF_FF80;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            rand_word = make_timer_word();
            send_word(rand_word, 1'b0, '0);
            if (k % DRAIN_EVERY == DRAIN_EVERY - 1) drain_reports();
         end
      end
      drain_reports();

      $display("run: %0d words sent, %0d polls, %0d binds granted, %0d channels bound",
               words_sent, polls_sent, binds_granted, bound_n);
      $display("run: %0d reports checked, %0d firings, limits 16/0/3/9/31/4, %0d mismatches",
               reports_checked, fires_seen, mismatch_count);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d reports still outstanding", pending_reports.size());
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
